>>> hdl/assert_macros.svh
// Assertion macros used by the semaphore RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CSEM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CSEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/csem_pkg.sv
// Types and constants of the counting semaphore.
`timescale 1ns / 1ps
`default_nettype none

package csem_pkg;

    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_SIGNAL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [3:0] OUT_GRANTED   = 4'd0;
    localparam logic [3:0] OUT_REFUSED   = 4'd1;
    localparam logic [3:0] OUT_QUEUED    = 4'd2;
    localparam logic [3:0] OUT_FULL      = 4'd3;
    localparam logic [3:0] OUT_UNIT_ADD  = 4'd4;
    localparam logic [3:0] OUT_WAKE      = 4'd5;
    localparam logic [3:0] OUT_TIMEOUT   = 4'd6;
    localparam logic [3:0] OUT_SUMMARY   = 4'd7;
    localparam logic [3:0] OUT_OVERFLOW  = 4'd8;

    localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;
    localparam logic [15:0] UNIT_MAX    = 16'hFFFF;
    localparam logic [15:0] UNIT_RESET  = 16'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  task_id;
        logic [31:0] timeout;
        logic [31:0] now_ticks;
    } t_in;

    typedef struct packed {
        logic [3:0]  outcome;
        logic [7:0]  result_task;
        logic [15:0] units_left;
        logic [31:0] next_deadline;
        logic        any_waiting;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SUMMARY
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_SHIFT,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [31:0] ins_deadline;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hdl/csem_cell.sv
// One waiter slot of the queue chain.
`timescale 1ns / 1ps
`default_nettype none

module csem_cell #(
    parameter int TASK_BITS = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire csem_pkg::t_cell_ctrl     i_ctrl,
    input  wire logic [TASK_BITS-1:0]     i_ins_task,
    input  wire logic                     i_left_valid,
    input  wire logic                     i_right_valid,
    input  wire logic [TASK_BITS-1:0]     i_right_task,
    input  wire logic [31:0]              i_right_deadline,
    input  wire logic [31:0]              i_now,
    output logic                          o_valid,
    output logic [TASK_BITS-1:0]          o_task,
    output logic [31:0]                   o_deadline,
    output logic                          o_expired
);
    import csem_pkg::*;

    logic                 r_valid, n_valid;
    logic [TASK_BITS-1:0] r_task, n_task;
    logic [31:0]          r_deadline, n_deadline;

    // A push lands in the first free slot; a rotate moves the head to the
    // first slot that is free after the shift.
    always_comb begin
        n_valid    = r_valid;
        n_task     = r_task;
        n_deadline = r_deadline;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
            end
            CELL_PUSH: begin
                if (!r_valid && i_left_valid) begin
                    n_valid    = 1'b1;
                    n_task     = i_ins_task;
                    n_deadline = i_ctrl.ins_deadline;
                end
            end
            CELL_SHIFT: begin
                n_valid    = i_right_valid;
                n_task     = i_right_task;
                n_deadline = i_right_deadline;
            end
            CELL_ROTATE: begin
                n_valid    = i_right_valid;
                n_task     = i_right_task;
                n_deadline = i_right_deadline;
                if (!i_right_valid && r_valid) begin
                    n_valid    = 1'b1;
                    n_task     = i_ins_task;
                    n_deadline = i_ctrl.ins_deadline;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task     <= n_task;
        r_deadline <= n_deadline;
    end

    assign o_valid    = r_valid;
    assign o_task     = r_task;
    assign o_deadline = r_deadline;
    assign o_expired  = r_valid && (r_deadline <= i_now);

endmodule

`default_nettype wire

>>> hdl/counting_semaphore_with_timeouts_unit.sv
// Top level of the counting semaphore with a queue of timed waiters.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Counting semaphore with a first-in first-out queue of up to QUEUE_DEPTH
// waiting tasks, each with a deadline. Wait and signal transactions are
// answered with one result each, so one of them can be accepted in every
// cycle while the result register is drained. A tick transaction steps
// through the waiters present when it is accepted, as the queue is a
// chain of cells that rotates by one slot per cycle, the head cell being
// either released (one timed-out result) or moved to the tail, and the
// summary result follows last. Results pass through a single output
// register, and a stalled output holds the chain. Writing the
// configuration register loads the unit count at once and leaves the
// queue alone; it is meant to be done while the block is idle.
module counting_semaphore_with_timeouts_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_BITS   = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire csem_pkg::t_in   i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output csem_pkg::t_out       o_out,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [15:0]     i_cfg_data
);
    import csem_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Control and datapath registers.
    t_state           r_state, n_state;
    logic [15:0]      r_units, n_units;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic [31:0]      r_now, n_now;
    logic [31:0]      r_earliest, n_earliest;
    logic             r_keep_any, n_keep_any;
    logic             r_out_valid;
    t_out             r_out;

    // Combinational decisions of the current cycle.
    logic             w_out_free;
    logic             w_in_fire;
    logic             w_emit;
    t_out             w_out;
    t_cell_ctrl       w_ctrl;
    logic [TASK_BITS-1:0] w_ins_task;
    logic [31:0]      w_cell_now;

    // Chain wiring; the slot past the last cell reads as empty.
    logic [QUEUE_DEPTH:0]   w_valid;
    logic [TASK_BITS-1:0]   w_task [QUEUE_DEPTH+1];
    logic [31:0]            w_deadline [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0] w_expired;

    // Task identifiers keep their low TASK_BITS bits, and come back out as
    // the low eight bits of the stored value.
    logic [TASK_BITS+7:0] w_in_task_ext;
    logic [TASK_BITS-1:0] w_in_task;
    logic [TASK_BITS+7:0] w_head_task_ext;
    logic [7:0]           w_in_task8;
    logic [7:0]           w_head_task8;

    logic [32:0] w_sum;
    logic [31:0] w_new_deadline;

    assign w_in_task_ext   = {{TASK_BITS{1'b0}}, i_in.task_id};
    assign w_in_task       = w_in_task_ext[TASK_BITS-1:0];
    assign w_in_task8      = w_in_task_ext[7:0] & 8'(w_in_task_ext[TASK_BITS-1:0]);
    assign w_head_task_ext = {8'b0, w_task[0]};
    assign w_head_task8    = w_head_task_ext[7:0];

    // Deadline of a new waiter, saturating on overflow.
    assign w_sum          = {1'b0, i_in.now_ticks} + {1'b0, i_in.timeout};
    assign w_new_deadline = w_sum[32] ? NO_DEADLINE : w_sum[31:0];

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_out_free;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // While idle the cells compare against the incoming tick time, so that
    // the expiry of every waiter is known in the cycle the tick arrives.
    assign w_cell_now = (r_state == ST_IDLE) ? i_in.now_ticks : r_now;

    assign w_valid[QUEUE_DEPTH]    = 1'b0;
    assign w_task[QUEUE_DEPTH]     = '0;
    assign w_deadline[QUEUE_DEPTH] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic w_left_valid;
        if (i == 0) begin : g_head
            assign w_left_valid = 1'b1;
        end else begin : g_body
            assign w_left_valid = w_valid[i-1];
        end

        csem_cell #(
            .TASK_BITS(TASK_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (w_ctrl),
            .i_ins_task      (w_ins_task),
            .i_left_valid    (w_left_valid),
            .i_right_valid   (w_valid[i+1]),
            .i_right_task    (w_task[i+1]),
            .i_right_deadline(w_deadline[i+1]),
            .i_now           (w_cell_now),
            .o_valid         (w_valid[i]),
            .o_task          (w_task[i]),
            .o_deadline      (w_deadline[i]),
            .o_expired       (w_expired[i])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire && (i_in.mode == MODE_TICK)) begin
                    n_state = (r_count == '0) ? ST_SUMMARY : ST_TICK;
                end
            end
            ST_TICK: begin
                if (w_out_free && (r_left == CNT_ONE)) begin
                    n_state = ST_SUMMARY;
                end
            end
            ST_SUMMARY: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Results, chain commands and register updates.
    always_comb begin
        w_emit              = 1'b0;
        w_out               = '0;
        w_out.units_left    = r_units;
        w_ctrl.op           = CELL_HOLD;
        w_ctrl.ins_deadline = w_new_deadline;
        w_ins_task          = w_in_task;
        n_units             = r_units;
        n_count             = r_count;
        n_left              = r_left;
        n_now               = r_now;
        n_earliest          = r_earliest;
        n_keep_any          = r_keep_any;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    unique case (i_in.mode)
                        MODE_WAIT: begin
                            w_emit              = 1'b1;
                            w_out.result_task   = w_in_task8;
                            w_out.last          = 1'b1;
                            w_out.any_waiting   = (r_count != '0);
                            if (r_units != '0) begin
                                n_units          = r_units - 16'd1;
                                w_out.units_left = r_units - 16'd1;
                                w_out.outcome    = OUT_GRANTED;
                            end else if (i_in.timeout == '0) begin
                                w_out.outcome = OUT_REFUSED;
                            end else if (r_count == CNT_FULL) begin
                                w_out.outcome = OUT_FULL;
                            end else begin
                                w_ctrl.op           = CELL_PUSH;
                                n_count             = r_count + CNT_ONE;
                                w_out.outcome       = OUT_QUEUED;
                                w_out.next_deadline = w_new_deadline;
                                w_out.any_waiting   = 1'b1;
                            end
                        end
                        MODE_SIGNAL: begin
                            w_emit     = 1'b1;
                            w_out.last = 1'b1;
                            if (r_count == '0) begin
                                if (r_units == UNIT_MAX) begin
                                    w_out.outcome = OUT_OVERFLOW;
                                end else begin
                                    n_units          = r_units + 16'd1;
                                    w_out.units_left = r_units + 16'd1;
                                    w_out.outcome    = OUT_UNIT_ADD;
                                end
                            end else begin
                                w_ctrl.op         = CELL_SHIFT;
                                n_count           = r_count - CNT_ONE;
                                w_out.outcome     = OUT_WAKE;
                                w_out.result_task = w_head_task8;
                                w_out.any_waiting = (r_count != CNT_ONE);
                            end
                        end
                        MODE_TICK: begin
                            n_now      = i_in.now_ticks;
                            n_left     = r_count;
                            n_earliest = NO_DEADLINE;
                            n_keep_any = |(w_valid[QUEUE_DEPTH-1:0] & ~w_expired);
                        end
                        MODE_NONE: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                // The head is examined once per cycle while the output is free; the chain
                // rotates so that survivors come back around in their original order.
                if (w_out_free) begin
                    n_left              = r_left - CNT_ONE;
                    w_ins_task          = w_task[0];
                    w_ctrl.ins_deadline = w_deadline[0];
                    if (w_expired[0]) begin
                        w_ctrl.op           = CELL_SHIFT;
                        n_count             = r_count - CNT_ONE;
                        w_emit              = 1'b1;
                        w_out.outcome       = OUT_TIMEOUT;
                        w_out.result_task   = w_head_task8;
                        w_out.next_deadline = w_deadline[0];
                        w_out.any_waiting   = r_keep_any;
                    end else begin
                        w_ctrl.op = CELL_ROTATE;
                        if (w_deadline[0] < r_earliest) begin
                            n_earliest = w_deadline[0];
                        end
                    end
                end
            end
            ST_SUMMARY: begin
                if (w_out_free) begin
                    w_emit              = 1'b1;
                    w_out.outcome       = OUT_SUMMARY;
                    w_out.next_deadline = r_earliest;
                    w_out.any_waiting   = (r_count != '0);
                    w_out.last          = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // A configuration write reloads the unit count.
        if (i_cfg_valid && o_cfg_ready) begin
            n_units = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_units     <= UNIT_RESET;
            r_count     <= '0;
            r_left      <= '0;
            r_keep_any  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_units    <= n_units;
            r_count    <= n_count;
            r_left     <= n_left;
            r_keep_any <= n_keep_any;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_earliest <= n_earliest;
        if (w_emit) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The waiter count always matches the occupied cells of the chain.
    `CSEM_ASSERT(a_count_matches_cells, 1'b1,
        $countones(w_valid[QUEUE_DEPTH-1:0]) == int'(r_count),
        "waiter count disagrees with the occupied cells")

    // The count never passes the queue depth.
    `CSEM_ASSERT(a_count_bounded, 1'b1, r_count <= CNT_FULL,
        "waiter count exceeds the queue depth")

    // A result that is not the last of its transaction comes from a tick in
    // progress, which must still be running.
    `CSEM_ASSERT(a_partial_in_tick, r_out_valid && !r_out.last,
        r_state == ST_TICK || r_state == ST_SUMMARY,
        "partial result outside a tick")

    // A tick never changes the unit count unless configuration is written.
    `CSEM_ASSERT_NEXT(a_tick_keeps_units, r_state != ST_IDLE && !i_cfg_valid,
        $stable(r_units), "unit count changed during a tick")

endmodule

`default_nettype wire

>>> sim/tb_counting_semaphore_with_timeouts_unit.sv
// Self-checking testbench for the counting semaphore unit with timed waiters.
`timescale 1ns / 1ps

module tb_counting_semaphore_with_timeouts_unit;

    import csem_pkg::*;

    localparam int     WAIT_SLOTS      = 16;
    localparam int     ITEMS_PER_PHASE = 67;
    localparam int     HOLD_CYCLES     = 150;
    // The slowest correct run is a few hundred items with up to 17 results
    // each, every result waiting on a receiver that stalls most cycles; the
    // limit leaves a wide margin.
    localparam longint LIMIT_NS        = 64'd10_000_000;

    typedef struct packed {
        logic [7:0]  tid;
        logic [31:0] deadline;
    } t_waiter;

    // Tracks the unit count and the waiter line, and holds the results that
    // the block owes for every request it has taken.
    class sem_tracker;
        logic [15:0] units;
        t_waiter     waiter_line[$];
        t_out        pending_results[$];
        int          mismatches;
        int          reported;
        int          requests;
        int          results_seen;
        int          outcome_count[9];

        function new();
            units = UNIT_RESET;
            mismatches = 0;
            reported = 0;
            requests = 0;
            results_seen = 0;
            foreach (outcome_count[i]) outcome_count[i] = 0;
        endfunction

        function void load_units(logic [15:0] value);
            units = value;
        endfunction

        function void owe(logic [3:0] outcome, logic [7:0] tid, logic [31:0] deadline,
                          logic last_flag);
            t_out r;
            r.outcome       = outcome;
            r.result_task   = tid;
            r.units_left    = units;
            r.next_deadline = deadline;
            r.any_waiting   = (waiter_line.size() != 0);
            r.last          = last_flag;
            pending_results.push_back(r);
        endfunction

        function void note_request(t_in req);
            logic [32:0] sum;
            logic [31:0] deadline;
            logic [31:0] earliest;
            t_waiter     head;
            t_waiter     kept[$];
            t_waiter     expired[$];
            requests++;
            case (req.mode)
                MODE_WAIT: begin
                    if (units != 16'd0) begin
                        units--;
                        owe(OUT_GRANTED, req.task_id, 32'd0, 1'b1);
                    end else if (req.timeout == 32'd0) begin
                        owe(OUT_REFUSED, req.task_id, 32'd0, 1'b1);
                    end else if (waiter_line.size() >= WAIT_SLOTS) begin
                        owe(OUT_FULL, req.task_id, 32'd0, 1'b1);
                    end else begin
                        // The deadline saturates instead of wrapping.
                        sum = {1'b0, req.now_ticks} + {1'b0, req.timeout};
                        deadline = sum[32] ? NO_DEADLINE : sum[31:0];
                        waiter_line.push_back('{tid: req.task_id, deadline: deadline});
                        owe(OUT_QUEUED, req.task_id, deadline, 1'b1);
                    end
                end
                MODE_SIGNAL: begin
                    if (waiter_line.size() == 0) begin
                        if (units == UNIT_MAX) begin
                            owe(OUT_OVERFLOW, 8'd0, 32'd0, 1'b1);
                        end else begin
                            units++;
                            owe(OUT_UNIT_ADD, 8'd0, 32'd0, 1'b1);
                        end
                    end else begin
                        head = waiter_line.pop_front();
                        owe(OUT_WAKE, head.tid, 32'd0, 1'b1);
                    end
                end
                MODE_TICK: begin
                    earliest = NO_DEADLINE;
                    foreach (waiter_line[i]) begin
                        if (waiter_line[i].deadline <= req.now_ticks) begin
                            expired.push_back(waiter_line[i]);
                        end else begin
                            kept.push_back(waiter_line[i]);
                            if (waiter_line[i].deadline < earliest) begin
                                earliest = waiter_line[i].deadline;
                            end
                        end
                    end
                    // Every release reports the line as it stands after the
                    // whole tick, so the line is trimmed first.
                    waiter_line = kept;
                    foreach (expired[i]) begin
                        owe(OUT_TIMEOUT, expired[i].tid, expired[i].deadline, 1'b0);
                    end
                    owe(OUT_SUMMARY, 8'd0, earliest, 1'b1);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(t_out got);
            t_out want;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("ERROR: unexpected result outcome %0d task %0h units %0d",
                             got.outcome, got.result_task, got.units_left);
                end
                return;
            end
            want = pending_results.pop_front();
            if (want.outcome <= OUT_OVERFLOW) outcome_count[want.outcome]++;
            if (got.outcome !== want.outcome || got.result_task !== want.result_task ||
                got.units_left !== want.units_left ||
                got.next_deadline !== want.next_deadline ||
                got.any_waiting !== want.any_waiting || got.last !== want.last) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("ERROR: result %0d expected outcome %0d task %h units %0d",
                             results_seen, want.outcome, want.result_task, want.units_left);
                    $display("       deadline %h waiting %b last %b",
                             want.next_deadline, want.any_waiting, want.last);
                    $display("       got outcome %0d task %h units %0d deadline %h",
                             got.outcome, got.result_task, got.units_left, got.next_deadline);
                    $display("       waiting %b last %b", got.any_waiting, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in         i_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = 16'd0;

    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    bit          hold_req      = 1'b0;
    bit          hold_seen     = 1'b0;
    int          hold_left     = 0;
    logic [31:0] tick_now      = 32'd0;

    sem_tracker  tracker;

    counting_semaphore_with_timeouts_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("ERROR: run did not finish in time");
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus
    // flips hold_req. The hold-off is counted down here at every edge.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // All handshakes are sampled at the edge where they complete.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) tracker.check_result(o_out);
            if (i_in_valid && o_in_ready) tracker.note_request(i_in);
            if (i_cfg_valid && o_cfg_ready) tracker.load_units(i_cfg_data);
        end
    end

    function automatic t_in make_req(logic [1:0] mode, logic [7:0] tid,
                                     logic [31:0] timeout, logic [31:0] now);
        t_in r;
        r.mode      = mode;
        r.task_id   = tid;
        r.timeout   = timeout;
        r.now_ticks = now;
        return r;
    endfunction

    // Random traffic follows a mostly advancing tick count so that waiters
    // queue up and later expire; now and then the count jumps anywhere.
    function automatic t_in random_req();
        t_in         r;
        int          pick;
        int          span;
        pick = $urandom_range(99);
        span = $urandom_range(9);
        if (pick < 45)      r.mode = MODE_WAIT;
        else if (pick < 70) r.mode = MODE_SIGNAL;
        else if (pick < 95) r.mode = MODE_TICK;
        else                r.mode = MODE_NONE;
        r.task_id = 8'($urandom_range(255));
        if (span == 0)      r.timeout = 32'd0;
        else if (span == 1) r.timeout = $urandom();
        else if (span == 2) r.timeout = 32'hFFFF_FFFF - 32'($urandom_range(3));
        else                r.timeout = 32'($urandom_range(1, 120));
        if ($urandom_range(19) == 0) tick_now = $urandom();
        else                         tick_now = tick_now + 32'($urandom_range(30));
        r.now_ticks = tick_now;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    // Valid stays high on return so that back-to-back requests need no gap.
    task automatic send_req(t_in req);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Waits until every owed result is in and the block has had time to
    // finish any request that produces nothing.
    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            while (tracker.pending_results.size() != 0) @(posedge i_clk);
            repeat (WAIT_SLOTS + 8) @(posedge i_clk);
        end while (tracker.pending_results.size() != 0);
    endtask

    task automatic write_units(logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          k;
        int          phase;
        int          sent;
        int          in_pct[4];
        int          out_pct[4];
        logic [15:0] phase_units[4];
        t_in         req;

        tracker = new();
        in_pct      = '{0, 63, 0, 27};
        out_pct     = '{0, 0, 63, 27};
        phase_units = '{16'd0, 16'd2, 16'd0, 16'($urandom_range(3))};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The reset count of one unit is taken by the first
        // wait, after which waits either get refused or join the line.
        send_req(make_req(MODE_WAIT, 8'hFF, 32'd0, 32'd0));
        send_req(make_req(MODE_WAIT, 8'h00, 32'd0, 32'hFFFF_FFFF));
        for (k = 0; k < WAIT_SLOTS; k++) begin
            if (k == 0) begin
                // Deadline that would wrap past the top of the tick range.
                send_req(make_req(MODE_WAIT, 8'hA5, 32'hFFFF_FFFF, 32'h0000_1000));
            end else if (k == 1) begin
                send_req(make_req(MODE_WAIT, 8'h5A, 32'hFFFF_FFFF, 32'd0));
            end else begin
                send_req(make_req(MODE_WAIT, 8'(k * 17), 32'(k * 10), 32'h100));
            end
        end
        // Line is full now.
        send_req(make_req(MODE_WAIT, 8'h3C, 32'd5, 32'h200));
        send_req(make_req(MODE_SIGNAL, 8'h00, 32'd0, 32'd0));
        send_req(make_req(MODE_WAIT, 8'h7E, 32'd1, 32'd0));
        // Tick at the top of the range releases all sixteen waiters.
        send_req(make_req(MODE_TICK, 8'h00, 32'd0, 32'hFFFF_FFFF));
        send_req(make_req(MODE_TICK, 8'hFF, 32'hFFFF_FFFF, 32'd0));
        send_req(make_req(MODE_SIGNAL, 8'h11, 32'd7, 32'd9));
        send_req(make_req(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // Full unit count: a signal with nobody waiting overflows.
        drain();
        write_units(UNIT_MAX);
        send_req(make_req(MODE_SIGNAL, 8'h00, 32'd0, 32'd0));
        send_req(make_req(MODE_WAIT, 8'h81, 32'd0, 32'd0));
        send_req(make_req(MODE_SIGNAL, 8'h00, 32'd0, 32'd0));

        // Random phases, each with its own unit count and idling mix. The
        // first phase also holds the receiver off for a long stretch so the
        // output backs up and the input stalls.
        for (phase = 0; phase < 4; phase++) begin
            drain();
            write_units(phase_units[phase]);
            in_idle_pct   = in_pct[phase];
            out_stall_pct = out_pct[phase];
            if (phase == 0) hold_req = ~hold_req;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                req = random_req();
                send_req(req);
                if (req.mode != MODE_NONE) sent++;
            end
        end

        in_idle_pct   = 0;
        out_stall_pct = 0;
        drain();

        $display("Run covered %0d requests and %0d results under four idling mixes.",
                 tracker.requests, tracker.results_seen);
        $display("Outcomes: grant %0d refuse %0d queue %0d full %0d add %0d wake %0d",
                 tracker.outcome_count[0], tracker.outcome_count[1],
                 tracker.outcome_count[2], tracker.outcome_count[3],
                 tracker.outcome_count[4], tracker.outcome_count[5]);
        $display("          timeout %0d summary %0d overflow %0d; mismatches %0d",
                 tracker.outcome_count[6], tracker.outcome_count[7],
                 tracker.outcome_count[8], tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
